[rtl/dqsr_pkg.sv]
// ----------------------------------------------------------------------------
// dqsr_pkg
// Shared types and constants of the double-ended queue with search and remove.
// ----------------------------------------------------------------------------
package dqsr_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CONTAINS   = 3'd4,
    OP_REMOVE     = 3'd5
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic push_front;  // every cell takes its left neighbor
    logic push_back;   // the first free cell takes the new value
    logic shift_down;  // every cell takes its right neighbor
    logic remove;      // cells at and after the first match take their right neighbor
  } cell_ctrl_t;

endpackage

[rtl/dqsr_in_if.sv]
// ----------------------------------------------------------------------------
// dqsr_in_if
// Request channel: opcode and value with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dqsr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [dqsr_pkg::OPCODE_W-1:0]         opcode;
  logic signed [dqsr_pkg::DATA_W-1:0]    item_value;

  modport source (output valid, output opcode, output item_value, input ready);
  modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

[rtl/dqsr_out_if.sv]
// ----------------------------------------------------------------------------
// dqsr_out_if
// Result channel: status, search flag, popped value, ends and count.
// ----------------------------------------------------------------------------
interface dqsr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [dqsr_pkg::STATUS_W-1:0]         status;
  logic                                  found;
  logic signed [dqsr_pkg::DATA_W-1:0]    popped_value;
  logic signed [dqsr_pkg::DATA_W-1:0]    front_value;
  logic signed [dqsr_pkg::DATA_W-1:0]    back_value;
  logic [dqsr_pkg::COUNT_W-1:0]          entry_count;
  logic                                  is_empty;

  modport source (output valid, output status, output found, output popped_value,
                  output front_value, output back_value, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input found, input popped_value,
                  input front_value, input back_value, input entry_count,
                  input is_empty, output ready);
endinterface

[rtl/dqsr_cell.sv]
// ----------------------------------------------------------------------------
// dqsr_cell
// One slot of the queue: holds an entry, compares it against the search
// value and shifts toward either neighbor.
// ----------------------------------------------------------------------------
module dqsr_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned SW  = 32,
  parameter int unsigned CW  = 5
) (
  input  logic                 clk_i,
  input  dqsr_pkg::cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]        count_i,
  input  logic [SW-1:0]        value_i,
  input  logic [SW-1:0]        left_i,
  input  logic [SW-1:0]        right_i,
  input  logic                 hit_i,
  input  logic [SW-1:0]        back_i,
  output logic [SW-1:0]        entry_o,
  output logic                 hit_o,
  output logic [SW-1:0]        back_o
);
  import dqsr_pkg::*;

  localparam logic [CW-1:0] SLOT = CW'(IDX);
  localparam logic [CW-1:0] NEXT = CW'(IDX + 1);

  logic [SW-1:0] entry_q, entry_d;
  logic          occupied;
  logic          is_back;

  assign occupied = count_i > SLOT;
  assign is_back  = count_i == NEXT;

  // first-match chain: high from the first matching slot onward
  assign hit_o  = hit_i | (occupied & (entry_q == value_i));
  // at most one slot is the back, so the chain is a plain or
  assign back_o = back_i | ({SW{is_back}} & entry_q);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push_front) begin
      entry_d = left_i;
    end else if (ctrl_i.push_back && count_i == SLOT) begin
      entry_d = value_i;
    end else if (ctrl_i.shift_down || (ctrl_i.remove && hit_o)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[rtl/deque_with_search_and_remove.sv]
// ----------------------------------------------------------------------------
// deque_with_search_and_remove
// Bounded double-ended queue of signed words with search and ordered removal.
// ----------------------------------------------------------------------------
// The queue is a row of DEPTH cells, front in cell 0. A push, pop, search or
// remove is applied at the transfer edge and its result is registered, so a
// new request is taken each cycle while the result side keeps up; when a
// result waits, requests stall. A search compares the value in every cell at
// once, and the first-match chain that runs through the row sets the length
// of the path in that cycle. Values are held in their low VALUE_WIDTH bits
// (at most 32) and reported zero-extended.
module deque_with_search_and_remove #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dqsr_in_if.sink           req_i,
  dqsr_out_if.source        rsp_o
);
  import dqsr_pkg::*;

  localparam int unsigned SW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [CW-1:0] count_q, count_d;
  logic          rsp_valid_q;
  status_e       status_q, status_d;
  logic          found_q, found_d;
  logic [SW-1:0] popped_q, popped_d;

  cell_ctrl_t    ctrl;
  logic          xfer;
  logic          empty;
  logic          full;
  logic [SW-1:0] value;

  logic [SW-1:0] entry [DEPTH];
  logic          hit   [DEPTH+1];
  logic [SW-1:0] back  [DEPTH+1];

  assign value       = req_i.item_value[SW-1:0];
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign xfer        = req_i.valid && req_i.ready;
  assign empty       = count_q == '0;
  assign full        = count_q == FULL_COUNT;

  assign hit[0]  = 1'b0;
  assign back[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [SW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = value;
    end else begin : g_mid
      assign left = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = entry[i];
    end else begin : g_inner
      assign right = entry[i+1];
    end

    dqsr_cell #(
      .IDX (i),
      .SW  (SW),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .value_i (value),
      .left_i  (left),
      .right_i (right),
      .hit_i   (hit[i]),
      .back_i  (back[i]),
      .entry_o (entry[i]),
      .hit_o   (hit[i+1]),
      .back_o  (back[i+1])
    );
  end

  always_comb begin
    ctrl     = '0;
    status_d = ST_OK;
    found_d  = 1'b0;
    popped_d = '0;
    count_d  = count_q;
    case (opcode_e'(req_i.opcode))
      OP_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.push_front = xfer;
          count_d         = count_q + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.push_back = xfer;
          count_d        = count_q + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.shift_down = xfer;
          popped_d        = entry[0];
          count_d         = count_q - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          popped_d = back[DEPTH];
          count_d  = count_q - 1'b1;
        end
      end
      OP_CONTAINS: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          found_d = hit[DEPTH];
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          found_d     = hit[DEPTH];
          ctrl.remove = xfer;
          count_d     = count_q - CW'(hit[DEPTH]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (xfer) begin
        count_q <= count_d;
      end
      if (xfer) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      status_q <= status_d;
      found_q  <= found_d;
      popped_q <= popped_d;
    end
  end

  // ends come straight from the cells and the count from its register, all of
  // which hold still while a result waits
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.found        = found_q;
  assign rsp_o.popped_value = DATA_W'(popped_q);
  assign rsp_o.front_value  = empty ? '0 : DATA_W'(entry[0]);
  assign rsp_o.back_value   = DATA_W'(back[DEPTH]);
  assign rsp_o.entry_count  = COUNT_W'(count_q);
  assign rsp_o.is_empty     = empty;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double-ended queue with search and remove. A
// directed table covers empty, extreme-value and unused-opcode cases, a fill
// overruns a full queue, then phased random traffic (fill, drain, search, noise)
// runs with bursty idling on both channels, checked against table or shadow deque.
// ----------------------------------------------------------------------------
module tb;
  import dqsr_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int          RANDOM_ITEMS = 600;
  localparam int          CALM_ITEMS   = 100;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          PRINT_LIMIT  = 200;

  // opcodes the block treats as no operation
  localparam logic [OPCODE_W-1:0] OP_NOP_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_NOP_7 = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    status_e                   status;
    logic                      found;
    logic signed [DATA_W-1:0]  popped;
    logic signed [DATA_W-1:0]  front;
    logic signed [DATA_W-1:0]  back;
    logic [COUNT_W-1:0]        count;
    logic                      empty;
  } deque_rsp_t;

  typedef struct {
    logic [OPCODE_W-1:0]       op;
    logic signed [DATA_W-1:0]  value;
    bit                        typed;
    deque_rsp_t                rsp;
  } table_row_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_SEARCH, MIX_NOISE} traffic_mix_e;

  logic clk_i;
  logic rst_ni;

  dqsr_in_if  req_if ();
  dqsr_out_if rsp_if ();

  deque_with_search_and_remove #(
    .DEPTH       (QUEUE_DEPTH),
    .VALUE_WIDTH (DATA_W)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic signed [DATA_W-1:0] shadow_q[$];
  deque_rsp_t               pending_rsp_q[$];
  table_row_t               table_q[$];
  int                       mismatch_cnt;
  int                       cycle_cnt;
  bit                       idle_on;
  bit                       stall_on;
  bit                       cur_typed;
  deque_rsp_t               cur_typed_rsp;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    cycle_cnt = 0;
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_cnt++;
  endtask

  // shadow deque update, returns the result the block should give
  function automatic deque_rsp_t apply_deque_op(logic [OPCODE_W-1:0] op,
                                                logic signed [DATA_W-1:0] v);
    deque_rsp_t r;
    int         hit;
    r.status = ST_OK;
    r.found  = 1'b0;
    r.popped = '0;
    hit      = -1;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_q.size() >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          shadow_q.push_front(v);
        end else begin
          shadow_q.push_back(v);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_POP_FRONT) begin
          r.popped = shadow_q.pop_front();
        end else begin
          r.popped = shadow_q.pop_back();
        end
      end
      OP_CONTAINS, OP_REMOVE: begin
        if (shadow_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < shadow_q.size() && hit < 0; i++) begin
            if (shadow_q[i] == v) hit = i;
          end
          if (hit >= 0) begin
            r.found = 1'b1;
            if (op == OP_REMOVE) shadow_q.delete(hit);
          end
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(shadow_q.size());
    r.empty = (shadow_q.size() == 0);
    r.front = r.empty ? '0 : shadow_q[0];
    r.back  = r.empty ? '0 : shadow_q[$];
    return r;
  endfunction

  // request and result monitor, both sampled at the rising edge
  always @(posedge clk_i) begin
    deque_rsp_t want;
    deque_rsp_t predicted;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        predicted = apply_deque_op(req_if.opcode, req_if.item_value);
        if (cur_typed) begin
          pending_rsp_q.push_back(cur_typed_rsp);
        end else begin
          pending_rsp_q.push_back(predicted);
        end
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_rsp_q.size() == 0) begin
          report_mismatch("result transfer with no request outstanding");
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", rsp_if.status, want.status));
          if (rsp_if.found !== want.found)
            report_mismatch($sformatf("found got %b want %b", rsp_if.found, want.found));
          if (rsp_if.popped_value !== want.popped)
            report_mismatch($sformatf("popped_value got %h want %h",
                                      rsp_if.popped_value, want.popped));
          if (rsp_if.front_value !== want.front)
            report_mismatch($sformatf("front_value got %h want %h",
                                      rsp_if.front_value, want.front));
          if (rsp_if.back_value !== want.back)
            report_mismatch($sformatf("back_value got %h want %h",
                                      rsp_if.back_value, want.back));
          if (rsp_if.entry_count !== want.count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      rsp_if.entry_count, want.count));
          if (rsp_if.is_empty !== want.empty)
            report_mismatch($sformatf("is_empty got %b want %b", rsp_if.is_empty, want.empty));
        end
      end
    end
  end

  // result side back-pressure in bursts of random length while stall_on is set
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_on && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(logic [OPCODE_W-1:0] op, logic signed [DATA_W-1:0] v,
                           bit typed, deque_rsp_t rsp);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.item_value <= v;
    cur_typed         <= typed;
    cur_typed_rsp     <= rsp;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_rsp_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic add_row(logic [OPCODE_W-1:0] op, logic signed [DATA_W-1:0] v, bit typed,
                         status_e st, logic fnd, logic signed [DATA_W-1:0] fr,
                         logic signed [DATA_W-1:0] bk, int cnt);
    table_row_t row;
    row.op         = op;
    row.value      = v;
    row.typed      = typed;
    row.rsp.status = st;
    row.rsp.found  = fnd;
    row.rsp.popped = '0;
    row.rsp.front  = fr;
    row.rsp.back   = bk;
    row.rsp.count  = COUNT_W'(cnt);
    row.rsp.empty  = (cnt == 0);
    table_q.push_back(row);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 3 && shadow_q.size() != 0) return shadow_q[$urandom_range(0, shadow_q.size() - 1)];
    if (r <= 5) return DATA_W'($signed($urandom_range(0, 6)) - 3);
    if (r == 6) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_opcode(traffic_mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 75) return r[0] ? OP_PUSH_BACK : OP_PUSH_FRONT;
        if (r < 85) return OP_CONTAINS;
        if (r < 95) return r[0] ? OP_POP_BACK : OP_POP_FRONT;
        return OP_REMOVE;
      end
      MIX_DRAIN: begin
        if (r < 60) return r[0] ? OP_POP_BACK : OP_POP_FRONT;
        if (r < 75) return OP_REMOVE;
        if (r < 85) return OP_CONTAINS;
        return r[0] ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end
      MIX_SEARCH: begin
        if (r < 30) return OP_CONTAINS;
        if (r < 55) return OP_REMOVE;
        if (r < 80) return r[0] ? OP_PUSH_BACK : OP_PUSH_FRONT;
        return r[0] ? OP_POP_BACK : OP_POP_FRONT;
      end
      default: return OPCODE_W'($urandom_range(0, 7));
    endcase
  endfunction

  initial begin
    deque_rsp_t   none;
    traffic_mix_e mix;
    int           sent;
    int           run_len;

    none.status = ST_OK;
    none.found  = 1'b0;
    none.popped = '0;
    none.front  = '0;
    none.back   = '0;
    none.count  = '0;
    none.empty  = 1'b1;

    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.opcode     = '0;
    req_if.item_value = '0;
    cur_typed         = 1'b0;
    cur_typed_rsp     = none;
    mismatch_cnt      = 0;
    idle_on           = 1'b1;
    stall_on          = 1'b1;

    // directed table: empty errors, extremes, unused opcodes, ordered removal
    add_row(OP_POP_FRONT,  '0,           1, ST_EMPTY, 0, '0, '0, 0);
    add_row(OP_POP_BACK,   32'sh1234,    1, ST_EMPTY, 0, '0, '0, 0);
    add_row(OP_CONTAINS,   '0,           1, ST_EMPTY, 0, '0, '0, 0);
    add_row(OP_REMOVE,     '1,           1, ST_EMPTY, 0, '0, '0, 0);
    add_row(OP_NOP_6,      32'sh5,       1, ST_OK,    0, '0, '0, 0);
    add_row(OP_PUSH_BACK,  VAL_MAX,      1, ST_OK,    0, VAL_MAX, VAL_MAX, 1);
    add_row(OP_PUSH_FRONT, VAL_MIN,      1, ST_OK,    0, VAL_MIN, VAL_MAX, 2);
    add_row(OP_CONTAINS,   VAL_MAX,      1, ST_OK,    1, VAL_MIN, VAL_MAX, 2);
    add_row(OP_CONTAINS,   '0,           1, ST_OK,    0, VAL_MIN, VAL_MAX, 2);
    add_row(OP_REMOVE,     '0,           1, ST_OK,    0, VAL_MIN, VAL_MAX, 2);
    add_row(OP_PUSH_BACK,  '1,           0, ST_OK,    0, '0, '0, 0);
    add_row(OP_PUSH_BACK,  '0,           0, ST_OK,    0, '0, '0, 0);
    add_row(OP_PUSH_FRONT, '1,           0, ST_OK,    0, '0, '0, 0);
    // duplicate value: only the front copy goes
    add_row(OP_REMOVE,     '1,           0, ST_OK,    0, '0, '0, 0);
    add_row(OP_REMOVE,     VAL_MAX,      0, ST_OK,    0, '0, '0, 0);
    add_row(OP_NOP_7,      32'sh3,       0, ST_OK,    0, '0, '0, 0);
    add_row(OP_POP_BACK,   VAL_MAX,      0, ST_OK,    0, '0, '0, 0);
    add_row(OP_POP_FRONT,  '0,           0, ST_OK,    0, '0, '0, 0);
    add_row(OP_REMOVE,     '1,           0, ST_OK,    0, '0, '0, 0);
    add_row(OP_POP_BACK,   '0,           1, ST_EMPTY, 0, '0, '0, 0);
    add_row(OP_NOP_7,      VAL_MIN,      1, ST_OK,    0, '0, '0, 0);

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (table_q[i]) begin
      send_item(table_q[i].op, table_q[i].value, table_q[i].typed, table_q[i].rsp);
    end
    wait_drained();

    // fill to capacity, then push into a full queue
    sent = 0;
    while (shadow_q.size() < QUEUE_DEPTH) begin
      send_item($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value(), 0, none);
      sent++;
    end
    repeat (3) begin
      send_item($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom, 0, none);
      sent++;
    end

    while (sent < RANDOM_ITEMS) begin
      mix     = traffic_mix_e'($urandom_range(0, 3));
      run_len = $urandom_range(8, 40);
      if (sent >= RANDOM_ITEMS - CALM_ITEMS) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end else begin
        idle_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 5) == 0) wait_drained();
      repeat (run_len) begin
        send_item(pick_opcode(mix), pick_value(), 0, none);
        sent++;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // results still expected at the end hold the drain wait until the cycle limit
  // ends the run with the fail message

endmodule
